>>> sv/psu_pkg.sv
// Shared types, codes and helpers for the particle swarm update engine.
// No dependencies; psu_ctrl, psu_dp and the top level import this package.
package psu_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int MAX_DIMS_DEF = 16;
	localparam int CFG_IW = 2;
	localparam int DIM_LIMIT = 16;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_FIT  = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_INERTIA = 2'd0,
		CFG_COGNITIVE = 2'd1,
		CFG_SOCIAL = 2'd2,
		CFG_DIMS = 2'd3
	} cfg_idx_t;

	localparam logic KIND_POS = 1'b0;
	localparam logic KIND_BEST = 1'b1;

	localparam logic signed [31:0] FIX_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] FIX_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INERTIA_RST = 32'sd45875;
	localparam logic signed [31:0] COGNITIVE_RST = 32'sd98304;
	localparam logic signed [31:0] SOCIAL_RST = 32'sd98304;
	localparam logic [4:0] DIMS_RST = 5'd16;
	localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

	typedef struct packed {
		logic clr;
		logic load;
		logic capture;
		logic pbrd;
		logic flags;
		logic rd;
		logic diff;
		logic mul;
		logic rnd;
		logic sum;
		logic emit;
		logic grd;
		logic gemit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_load;
		logic is_fit;
		logic is_read;
		logic dim_last;
		logic out_busy;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(FIX_MAX)) begin
			r = FIX_MAX;
		end else if (v < 64'(FIX_MIN)) begin
			r = FIX_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/psu_in_if.sv
// Request channel of the particle swarm update engine.
// Depends on nothing but the handshake convention valid and ready.
interface psu_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [5:0]  particle_index;
	logic [3:0]  dim_index;
	logic [31:0] position_value;
	logic [31:0] fitness;

	modport source(output valid, req_type, particle_index, dim_index, position_value, fitness,
		input ready);
	modport sink(input valid, req_type, particle_index, dim_index, position_value, fitness,
		output ready);
endinterface

>>> sv/psu_out_if.sv
// Result channel of the particle swarm update engine.
// Depends on nothing but the handshake convention valid and ready.
interface psu_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [5:0]  out_particle;
	logic [3:0]  out_dim;
	logic [31:0] value;
	logic [31:0] best_fitness;
	logic        last;

	modport source(output valid, kind, out_particle, out_dim, value, best_fitness, last,
		input ready);
	modport sink(input valid, kind, out_particle, out_dim, value, best_fitness, last,
		output ready);
endinterface

>>> sv/psu_cfg_if.sv
// Configuration write channel of the particle swarm update engine.
// Depends on nothing but the handshake convention valid and ready.
interface psu_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/psu_ctrl.sv
// Sequencer of the particle swarm update engine: one-hot state machine issuing commands.
// Depends on psu_pkg for the command and status structs.
module psu_ctrl import psu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		ST_CLEAR = 12'b0000_0000_0001,
		ST_IDLE  = 12'b0000_0000_0010,
		ST_PBRD  = 12'b0000_0000_0100,
		ST_FLAG  = 12'b0000_0000_1000,
		ST_RDA   = 12'b0000_0001_0000,
		ST_DIFF  = 12'b0000_0010_0000,
		ST_MUL   = 12'b0000_0100_0000,
		ST_RND   = 12'b0000_1000_0000,
		ST_SUM   = 12'b0001_0000_0000,
		ST_EMIT  = 12'b0010_0000_0000,
		ST_GRD   = 12'b0100_0000_0000,
		ST_GEMIT = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.load = sts.is_load;
					if (sts.is_fit) begin
						state_d = ST_PBRD;
					end else if (sts.is_read) begin
						state_d = ST_GRD;
					end
				end
			end
			ST_PBRD: begin
				cmd.pbrd = 1'b1;
				state_d = ST_FLAG;
			end
			ST_FLAG: begin
				cmd.flags = 1'b1;
				state_d = ST_RDA;
			end
			ST_RDA: begin
				cmd.rd = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d = sts.dim_last ? ST_IDLE : ST_RDA;
				end
			end
			ST_GRD: begin
				cmd.grd = 1'b1;
				state_d = ST_GEMIT;
			end
			ST_GEMIT: begin
				if (!sts.out_busy) begin
					cmd.gemit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

>>> sv/psu_dp.sv
// Datapath of the particle swarm update engine: stores, weights, arithmetic, result register.
// Depends on psu_pkg; driven by the command struct from psu_ctrl.
module psu_dp import psu_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  req_type,
	input  logic [5:0]  particle_index,
	input  logic [3:0]  dim_index,
	input  logic [31:0] position_value,
	input  logic [31:0] fitness,
	input  logic        cfg_valid,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [5:0]  out_particle,
	output logic [3:0]  out_dim,
	output logic [31:0] out_value,
	output logic [31:0] out_best_fitness,
	output logic        out_last,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW = PW + DW;
	localparam int DEPTH = MAX_PARTICLES * (2 ** DW);
	localparam int NLIM = (MAX_DIMS < DIM_LIMIT) ? MAX_DIMS : DIM_LIMIT;

	logic signed [31:0] pos_mem [DEPTH];
	logic signed [31:0] vel_mem [DEPTH];
	logic signed [31:0] pb_mem [DEPTH];
	logic signed [31:0] pbf_mem [MAX_PARTICLES];
	logic signed [31:0] gb_mem [MAX_DIMS];

	logic signed [31:0] w_in_q, w_cog_q, w_soc_q;
	logic [4:0] dims_q;
	logic [AW-1:0] clr_cnt_q;
	logic [PW-1:0] p_q;
	logic [3:0] d_q, i_q;
	logic d_ok_q;
	logic signed [31:0] fit_q, gbf_q, pbf_rd_q;
	logic gl_q, pl_q;
	logic signed [31:0] x_q, v_q, pbr_q, gbr_q;
	logic signed [31:0] dp_q, dg_q;
	logic signed [63:0] pi_q, pc_q, ps_q;
	logic signed [47:0] ti_q, tc_q, ts_q;
	logic signed [31:0] vn_q;
	logic out_valid_q;

	logic [AW-1:0] ld_addr, cur_addr;
	logic [DW-1:0] ia;
	logic [4:0] n_dims;
	logic signed [31:0] pb_c, gb_c, xn_c;
	logic signed [32:0] dpw, dgw, xsw;
	logic signed [49:0] sum_w;
	logic p_ok, d_in_ok;

	assign ia = DW'(i_q);
	assign cur_addr = {p_q, ia};
	assign ld_addr = {PW'(particle_index), DW'(dim_index)};
	assign p_ok = {26'd0, particle_index} < 32'(MAX_PARTICLES);
	assign d_in_ok = {28'd0, dim_index} < 32'(MAX_DIMS);

	always_comb begin
		if (dims_q == 5'd0) begin
			n_dims = 5'd1;
		end else if ({27'd0, dims_q} > 32'(NLIM)) begin
			n_dims = 5'(NLIM);
		end else begin
			n_dims = dims_q;
		end
	end

	assign sts.clr_done = clr_cnt_q == AW'(DEPTH - 1);
	assign sts.is_load = (req_type == REQ_LOAD) && p_ok && d_in_ok;
	assign sts.is_fit = (req_type == REQ_FIT) && p_ok;
	assign sts.is_read = req_type == REQ_READ;
	assign sts.dim_last = ({1'b0, i_q} + 5'd1) == n_dims;
	assign sts.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_in_q <= INERTIA_RST;
			w_cog_q <= COGNITIVE_RST;
			w_soc_q <= SOCIAL_RST;
			dims_q <= DIMS_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INERTIA: w_in_q <= cfg_data;
				CFG_COGNITIVE: w_cog_q <= cfg_data;
				CFG_SOCIAL: w_soc_q <= cfg_data;
				CFG_DIMS: dims_q <= cfg_data[4:0];
				default: dims_q <= dims_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			i_q <= '0;
			gl_q <= 1'b0;
			pl_q <= 1'b0;
			gbf_q <= FIX_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.capture) begin
				i_q <= '0;
			end else if (cmd.emit) begin
				i_q <= i_q + 4'd1;
			end
			if (cmd.flags) begin
				gl_q <= fit_q < gbf_q;
				pl_q <= fit_q < pbf_rd_q;
				if (fit_q < gbf_q) begin
					gbf_q <= fit_q;
				end
			end
			if (cmd.emit || cmd.gemit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			p_q <= PW'(particle_index);
			d_q <= dim_index;
			d_ok_q <= d_in_ok;
			fit_q <= fitness;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_mem[ld_addr] <= position_value;
		end else if (cmd.emit) begin
			pos_mem[cur_addr] <= xn_c;
		end
		if (cmd.rd) begin
			x_q <= pos_mem[cur_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			vel_mem[clr_cnt_q] <= '0;
		end else if (cmd.emit) begin
			vel_mem[cur_addr] <= vn_q;
		end
		if (cmd.rd) begin
			v_q <= vel_mem[cur_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && pl_q) begin
			pb_mem[cur_addr] <= x_q;
		end
		if (cmd.rd) begin
			pbr_q <= pb_mem[cur_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			pbf_mem[clr_cnt_q[AW-1:DW]] <= FIX_MAX;
		end else if (cmd.flags && (fit_q < pbf_rd_q)) begin
			pbf_mem[p_q] <= fit_q;
		end
		if (cmd.pbrd) begin
			pbf_rd_q <= pbf_mem[p_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr && ({{(32-DW){1'b0}}, clr_cnt_q[DW-1:0]} < 32'(MAX_DIMS))) begin
			gb_mem[clr_cnt_q[DW-1:0]] <= '0;
		end else if (cmd.emit && gl_q) begin
			gb_mem[ia] <= x_q;
		end
		if (cmd.rd) begin
			gbr_q <= gb_mem[ia];
		end else if (cmd.grd) begin
			gbr_q <= gb_mem[DW'(d_q)];
		end
	end

	assign pb_c = pl_q ? x_q : pbr_q;
	assign gb_c = gl_q ? x_q : gbr_q;
	assign dpw = {pb_c[31], pb_c} - {x_q[31], x_q};
	assign dgw = {gb_c[31], gb_c} - {x_q[31], x_q};
	assign sum_w = 50'(ti_q) + 50'(tc_q) + 50'(ts_q);
	assign xsw = {x_q[31], x_q} + {vn_q[31], vn_q};
	assign xn_c = sat32(64'(xsw));

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dp_q <= sat32(64'(dpw));
			dg_q <= sat32(64'(dgw));
		end
		if (cmd.mul) begin
			pi_q <= 64'(w_in_q) * 64'(v_q);
			pc_q <= 64'(w_cog_q) * 64'(dp_q);
			ps_q <= 64'(w_soc_q) * 64'(dg_q);
		end
		if (cmd.rnd) begin
			ti_q <= 48'((pi_q + ROUND_HALF) >>> 16);
			tc_q <= 48'((pc_q + ROUND_HALF) >>> 16);
			ts_q <= 48'((ps_q + ROUND_HALF) >>> 16);
		end
		if (cmd.sum) begin
			vn_q <= sat32(64'(sum_w));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind <= KIND_POS;
			out_particle <= 6'(p_q);
			out_dim <= i_q;
			out_value <= xn_c;
			out_best_fitness <= gbf_q;
			out_last <= sts.dim_last;
		end else if (cmd.gemit) begin
			out_kind <= KIND_BEST;
			out_particle <= '0;
			out_dim <= d_q;
			out_value <= d_ok_q ? gbr_q : '0;
			out_best_fitness <= gbf_q;
			out_last <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/particle_swarm_update_top.sv
// Top level of the particle swarm update engine: sequencer plus datapath.
// Depends on psu_pkg, the three channel interfaces, psu_ctrl and psu_dp.
//
//   channel  role    word carried
//   in_ch    sink    req_type, particle_index, dim_index, position_value, fitness
//   out_ch   source  kind, out_particle, out_dim, value, best_fitness, last
//   cfg      sink    index, data (always ready)
//
// A load is written to the position store as it is taken; a best read passes GRD and
// GEMIT before its result word is registered. A fitness report reads the personal best
// fitness, sets the best flags, then runs the read, difference, multiply, round, sum and
// write steps per dimension in use. After reset a clearing pass over all MAX_PARTICLES *
// 2**ceil(log2(MAX_DIMS)) velocity entries (1024 by default) precedes the first request.
// A stalled result word holds the sequencer; one word waits in the output register.
module particle_swarm_update_top import psu_pkg::*; #(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	parameter int MAX_DIMS = MAX_DIMS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	psu_in_if.sink   in_ch,
	psu_out_if.source out_ch,
	psu_cfg_if.sink  cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	psu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	psu_dp #(
		.MAX_PARTICLES(MAX_PARTICLES),
		.MAX_DIMS(MAX_DIMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req_type(in_ch.req_type),
		.particle_index(in_ch.particle_index),
		.dim_index(in_ch.dim_index),
		.position_value(in_ch.position_value),
		.fitness(in_ch.fitness),
		.cfg_valid(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_kind(out_ch.kind),
		.out_particle(out_ch.out_particle),
		.out_dim(out_ch.out_dim),
		.out_value(out_ch.value),
		.out_best_fitness(out_ch.best_fitness),
		.out_last(out_ch.last),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

>>> test/psu_tb_if.sv
// Testbench-side note: the block's interfaces are compiled from sv/.
// This file holds nothing but a helper package of test constants.
// Depends on psu_pkg.
package psu_tb_pkg;
	import psu_pkg::*;
	localparam int TB_PARTS = 64;
	localparam int TB_DIMS = 16;
endpackage

>>> test/tb.sv
// Self-checking testbench of particle_swarm_update_top: a directed table, then random
// load/report/read traffic, with every result word checked against an in-bench predictor.
// Depends on psu_pkg, psu_tb_pkg, the three channel interfaces and the block's RTL.
module tb;
	import psu_pkg::*;
	import psu_tb_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [5:0]  part;
		logic [3:0]  dim;
		logic [31:0] val;
		logic [31:0] fit;
		logic        last;
	} word_t;

	typedef struct packed {
		word_t       w;
		logic        chk;
		logic [31:0] cval;
		logic [31:0] cfit;
	} exp_t;

	typedef struct packed {
		req_t        req;
		logic [5:0]  part;
		logic [3:0]  dim;
		logic [31:0] pos;
		logic [31:0] fit;
		logic        chk;
		logic [31:0] exp_val;
		logic [31:0] exp_fit;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	psu_in_if in_ch();
	psu_out_if out_ch();
	psu_cfg_if cfg();

	particle_swarm_update_top uut(.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg(cfg));

	always #5 clk = ~clk;

	logic signed [31:0] w_in, w_cog, w_soc;
	logic [4:0] dims_reg;
	logic signed [31:0] pos_m [TB_PARTS*TB_DIMS];
	logic signed [31:0] vel_m [TB_PARTS*TB_DIMS];
	logic signed [31:0] pb_pos [TB_PARTS*TB_DIMS];
	logic signed [31:0] pb_fit [TB_PARTS];
	logic signed [31:0] gb_pos [TB_DIMS];
	logic signed [31:0] gb_fit;
	bit pos_set [TB_PARTS*TB_DIMS];
	bit pb_set [TB_PARTS*TB_DIMS];
	exp_t expected_words[$];
	row_t directed[$];
	int errors = 0;
	int cycles = 0;

	function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
		if (v > 64'sh7fffffff) return 32'sh7fffffff;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd32768;
		return p >>> 16;
	endfunction

	function automatic int active_dims();
		int n;
		n = dims_reg;
		if (n < 1) n = 1;
		if (n > TB_DIMS) n = TB_DIMS;
		return n;
	endfunction

	function automatic bit pos_ready(input logic [5:0] p, input int n);
		for (int i = 0; i < n; i++) begin
			if (!pos_set[int'(p)*TB_DIMS+i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit pb_ready(input logic [5:0] p, input int n);
		for (int i = 0; i < n; i++) begin
			if (!pb_set[int'(p)*TB_DIMS+i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic swarm_predict(input req_t req, input logic [5:0] p, input logic [3:0] d,
		input logic signed [31:0] pos, input logic signed [31:0] fit);
		int n, b;
		logic signed [31:0] x, dp, dg, v;
		logic signed [63:0] s;
		word_t w;
		exp_t ex;
		case (req)
			REQ_LOAD: begin
				pos_m[p*TB_DIMS+d] = pos;
				pos_set[p*TB_DIMS+d] = 1'b1;
			end
			REQ_READ: begin
				w = '{KIND_BEST, 6'd0, d, gb_pos[d], gb_fit, 1'b1};
				ex = '{w, 1'b0, 32'd0, 32'd0};
				expected_words.push_back(ex);
			end
			REQ_FIT: begin
				n = active_dims();
				b = p*TB_DIMS;
				if (fit < gb_fit) begin
					gb_fit = fit;
					for (int i = 0; i < n; i++) gb_pos[i] = pos_m[b+i];
				end
				if (fit < pb_fit[p]) begin
					pb_fit[p] = fit;
					for (int i = 0; i < n; i++) begin
						pb_pos[b+i] = pos_m[b+i];
						pb_set[b+i] = 1'b1;
					end
				end
				for (int i = 0; i < n; i++) begin
					x = pos_m[b+i];
					dp = clip32(64'(pb_pos[b+i]) - 64'(x));
					dg = clip32(64'(gb_pos[i]) - 64'(x));
					s = qmul(w_in, vel_m[b+i]) + qmul(w_cog, dp) + qmul(w_soc, dg);
					v = clip32(s);
					vel_m[b+i] = v;
					x = clip32(64'(x) + 64'(v));
					pos_m[b+i] = x;
					w = '{KIND_POS, p, 4'(i), x, gb_fit, (i+1 == n)};
					ex = '{w, 1'b0, 32'd0, 32'd0};
					expected_words.push_back(ex);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("FAIL particle_swarm_update_top");
			$finish;
		end
	end

	// Result sink with random stalls.
	int stall = 0;
	always @(posedge clk) begin
		word_t got;
		exp_t e;
		if (out_ch.valid && out_ch.ready) begin
			got = '{out_ch.kind, out_ch.out_particle, out_ch.out_dim, out_ch.value,
				out_ch.best_fitness, out_ch.last};
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word expected none actual %h", $time, got);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (got !== e.w) begin
					$display("%0t mismatch expected %h actual %h", $time, e.w, got);
					errors++;
				end
				if (e.chk && (got.val !== e.cval || got.fit !== e.cfit)) begin
					$display("%0t table mismatch expected %h/%h actual %h/%h", $time,
						e.cval, e.cfit, got.val, got.fit);
					errors++;
				end
			end
			stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
		end
		if (stall > 0) begin
			stall--;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= 1;
		end
	end

	task automatic send_word(input row_t r, input int gap);
		exp_t ex;
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.req_type <= r.req;
		in_ch.particle_index <= r.part;
		in_ch.dim_index <= r.dim;
		in_ch.position_value <= r.pos;
		in_ch.fitness <= r.fit;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		swarm_predict(r.req, r.part, r.dim, r.pos, r.fit);
		if (r.chk && expected_words.size() > 0) begin
			ex = expected_words[expected_words.size()-1];
			ex.chk = 1'b1;
			ex.cval = r.exp_val;
			ex.cfit = r.exp_fit;
			expected_words[expected_words.size()-1] = ex;
		end
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		case (idx)
			CFG_INERTIA: w_in = data;
			CFG_COGNITIVE: w_cog = data;
			CFG_SOCIAL: w_soc = data;
			default: dims_reg = data[4:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (expected_words.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic int rand_gap();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 65535) << $urandom_range(0, 8);
			3: return -($urandom_range(0, 65535) << $urandom_range(0, 8));
			default: return $urandom();
		endcase
	endfunction

	task automatic load_particle(input logic [5:0] p);
		row_t r;
		for (int d = 0; d < TB_DIMS; d++) begin
			r = '{REQ_LOAD, p, 4'(d), rand_word(), 32'd0, 1'b0, 32'd0, 32'd0};
			send_word(r, rand_gap());
		end
	endtask

	row_t r;
	initial begin
		in_ch.valid = 0;
		in_ch.req_type = REQ_LOAD;
		in_ch.particle_index = 0;
		in_ch.dim_index = 0;
		in_ch.position_value = 0;
		in_ch.fitness = 0;
		cfg.valid = 0;
		cfg.index = CFG_INERTIA;
		cfg.data = 0;
		out_ch.ready = 1;
		w_in = INERTIA_RST;
		w_cog = COGNITIVE_RST;
		w_soc = SOCIAL_RST;
		dims_reg = DIMS_RST;
		for (int i = 0; i < TB_PARTS*TB_DIMS; i++) begin
			pos_m[i] = 0;
			vel_m[i] = 0;
			pb_pos[i] = 0;
			pos_set[i] = 0;
			pb_set[i] = 0;
		end
		for (int i = 0; i < TB_PARTS; i++) pb_fit[i] = FIX_MAX;
		for (int i = 0; i < TB_DIMS; i++) gb_pos[i] = 0;
		gb_fit = FIX_MAX;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed table: read after reset, bogus type, loads of extremes, reports.
		directed.push_back('{REQ_READ, 6'd0, 4'd0, 32'd0, 32'd0, 1'b1, 32'd0, FIX_MAX});
		directed.push_back('{REQ_READ, 6'd63, 4'd15, 32'hffffffff, 32'd0, 1'b1, 32'd0,
			FIX_MAX});
		directed.push_back('{REQ_NONE, 6'd5, 4'd3, 32'hffffffff, 32'hffffffff, 1'b0, 32'd0,
			32'd0});
		for (int d = 0; d < TB_DIMS; d++) begin
			directed.push_back('{REQ_LOAD, 6'd0, 4'(d), (d[0] ? FIX_MAX : FIX_MIN), 32'd0,
				1'b0, 32'd0, 32'd0});
			if (d < 4) directed.push_back('{REQ_LOAD, 6'd63, 4'(d), 32'(d << 16), 32'd0,
				1'b0, 32'd0, 32'd0});
		end
		foreach (directed[i]) send_word(directed[i], rand_gap());
		directed.delete();
		drain();
		cfg_write(CFG_DIMS, 32'd4);
		for (int d = 0; d < 4; d++)
			directed.push_back('{REQ_LOAD, 6'd63, 4'(d), 32'(d << 16), 32'd0, 1'b0, 32'd0,
				32'd0});
		directed.push_back('{REQ_FIT, 6'd63, 4'd0, 32'd0, 32'h80000000, 1'b0, 32'd0, 32'd0});
		directed.push_back('{REQ_FIT, 6'd63, 4'd0, 32'd0, 32'h7ffffffe, 1'b0, 32'd0, 32'd0});
		directed.push_back('{REQ_READ, 6'd0, 4'd9, 32'd0, 32'd0, 1'b1, 32'd0, 32'h80000000});
		directed.push_back('{REQ_FIT, 6'd0, 4'd0, 32'd0, 32'h80000000, 1'b0, 32'd0, 32'd0});
		foreach (directed[i]) send_word(directed[i], rand_gap());
		drain();

		// Random phases, each with its own weight setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					cfg_write(CFG_INERTIA, 32'h7fffffff);
					cfg_write(CFG_COGNITIVE, 32'h80000000);
					cfg_write(CFG_SOCIAL, 32'h7fffffff);
					cfg_write(CFG_DIMS, 32'd1);
				end
				1: begin
					cfg_write(CFG_INERTIA, 32'h80000000);
					cfg_write(CFG_COGNITIVE, 32'h7fffffff);
					cfg_write(CFG_SOCIAL, 32'h80000000);
					cfg_write(CFG_DIMS, 32'd0);
				end
				2: begin
					cfg_write(CFG_INERTIA, INERTIA_RST);
					cfg_write(CFG_COGNITIVE, COGNITIVE_RST);
					cfg_write(CFG_SOCIAL, SOCIAL_RST);
					cfg_write(CFG_DIMS, 32'd31);
				end
				default: begin
					cfg_write(CFG_INERTIA, rand_word());
					cfg_write(CFG_COGNITIVE, rand_word());
					cfg_write(CFG_SOCIAL, rand_word());
					cfg_write(CFG_DIMS, $urandom_range(0, 31));
				end
			endcase
			for (int k = 0; k < 16; k++) begin
				logic [5:0] p;
				int n;
				logic signed [31:0] f;
				bit skip;
				p = ($urandom_range(0, 7) == 7) ? 6'd63 : 6'($urandom_range(0, 6));
				skip = 1'b0;
				case ($urandom_range(0, 9))
					0: load_particle(p);
					1: begin
						r = '{REQ_READ, 6'($urandom), 4'($urandom), rand_word(), rand_word(),
							1'b0, 32'd0, 32'd0};
						send_word(r, rand_gap());
					end
					2: begin
						r = '{REQ_NONE, 6'($urandom), 4'($urandom), rand_word(), rand_word(),
							1'b0, 32'd0, 32'd0};
						send_word(r, rand_gap());
					end
					default: begin
						n = active_dims();
						if (!pos_ready(p, n)) load_particle(p);
						f = rand_word();
						if (!pb_ready(p, n)) begin
							if (pb_fit[p] == FIX_MIN) begin
								skip = 1'b1;
							end else if (!(f < pb_fit[p])) begin
								f = pb_fit[p] - 32'sd1;
							end
						end
						if (!skip) begin
							r = '{REQ_FIT, p, 4'($urandom), rand_word(), f, 1'b0, 32'd0,
								32'd0};
							send_word(r, rand_gap());
						end
					end
				endcase
			end
			drain();
		end

		if (errors == 0 && expected_words.size() == 0) begin
			$display("PASS particle_swarm_update_top");
		end else begin
			$display("FAIL particle_swarm_update_top");
		end
		$finish;
	end
endmodule
